[hw/rtl/seg_pkg.sv]
package seg_pkg;

    // Default coordinate width, Q11.4 at 16 bits.
    localparam int COORD_BITS      = 16;
    // Default fraction bits of the line parameters.
    localparam int PARAM_FRAC_BITS = 16;
    // Fixed width of the one_minus_r and one_minus_s results.
    localparam int PARAM_BITS      = 24;

    typedef enum logic [1:0] {
        STAT_COLLINEAR = 2'd0,
        STAT_PARALLEL  = 2'd1,
        STAT_OUTSIDE   = 2'd2,
        STAT_HIT       = 2'd3
    } status_t;

endpackage

[hw/rtl/seg_dly.sv]
module seg_dly #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg [0:DEPTH-1];
    logic [WIDTH-1:0] data_reg  [0:DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < DEPTH; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg[0] <= in_data;
        for (int k = 1; k < DEPTH; k++)
        begin
            data_reg[k] <= data_reg[k-1];
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule

[hw/rtl/seg_div.sv]
module seg_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 35,
    parameter int SHIFT = 17,
    parameter int QB    = 25,
    parameter int OUT_W = 24
) (
    input  logic                    clk,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic signed [OUT_W-1:0] quo
);

    localparam int RA = NUM_W + SHIFT;
    localparam int RB = QB + DEN_W + 1;
    localparam int RW = (RA > RB) ? RA : RB;
    localparam logic [QB-1:0] HALF = QB'(1) << (OUT_W - 1);

    logic [NUM_W-1:0] nmag_a_reg;
    logic [DEN_W-1:0] dmag_a_reg;
    logic             neg_a_reg;

    logic [RW-1:0]    r_reg   [0:QB];
    logic [QB-1:0]    q_reg   [0:QB];
    logic [DEN_W-1:0] d_reg   [0:QB];
    logic             neg_reg [0:QB];
    logic             ovf_reg [0:QB];

    logic [RW-1:0]    r_init;
    logic [QB:0]      q_plus;
    logic [QB-1:0]    m_val;
    logic [QB-1:0]    res_next;
    logic [OUT_W-1:0] quo_reg;

    // Magnitudes and the sign of the quotient.
    always_ff @(posedge clk)
    begin
        nmag_a_reg <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        dmag_a_reg <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        neg_a_reg  <= num[NUM_W-1] ^ den[DEN_W-1];
    end

    // Scaled numerator and the check for a quotient too large for QB bits.
    assign r_init = RW'({nmag_a_reg, {SHIFT{1'b0}}});

    always_ff @(posedge clk)
    begin
        r_reg[0]   <= r_init;
        q_reg[0]   <= '0;
        d_reg[0]   <= dmag_a_reg;
        neg_reg[0] <= neg_a_reg;
        ovf_reg[0] <= (r_init >> QB) >= RW'(dmag_a_reg);
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 0; j < QB; j++)
    begin : g_bit
        localparam int I = QB - 1 - j;
        logic [DEN_W:0]  hi;
        logic            ge;
        logic [DEN_W:0]  diff;
        logic [RW-1:0]   r_next;

        always_comb
        begin
            hi     = r_reg[j][I +: DEN_W+1];
            ge     = hi >= {1'b0, d_reg[j]};
            diff   = hi - {1'b0, d_reg[j]};
            r_next = r_reg[j];
            if (ge)
            begin
                r_next[I +: DEN_W+1] = diff;
            end
        end

        always_ff @(posedge clk)
        begin
            r_reg[j+1]   <= r_next;
            q_reg[j+1]   <= {q_reg[j][QB-2:0], ge};
            d_reg[j+1]   <= d_reg[j];
            neg_reg[j+1] <= neg_reg[j];
            ovf_reg[j+1] <= ovf_reg[j];
        end
    end

    // Round half away from zero, saturate, then apply the sign.
    always_comb
    begin
        q_plus = {1'b0, q_reg[QB]} + (QB+1)'(1);
        m_val  = q_plus[QB:1];
        if (!neg_reg[QB])
        begin
            res_next = (ovf_reg[QB] || m_val > HALF - QB'(1)) ? HALF - QB'(1) : m_val;
        end
        else
        begin
            res_next = (ovf_reg[QB] || m_val > HALF) ? -HALF : -m_val;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= res_next[OUT_W-1:0];
    end

    assign quo = $signed(quo_reg);

endmodule

[hw/rtl/seg_cross.sv]
module seg_cross #(
    parameter int C = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [C-1:0]     ax,
    input  logic signed [C-1:0]     ay,
    input  logic signed [C-1:0]     bx,
    input  logic signed [C-1:0]     by,
    input  logic signed [C-1:0]     cx,
    input  logic signed [C-1:0]     cy,
    input  logic signed [C-1:0]     dx,
    input  logic signed [C-1:0]     dy,
    output logic                    out_valid,
    output logic signed [C-1:0]     ax_out,
    output logic signed [C-1:0]     ay_out,
    output logic signed [C:0]       bax_out,
    output logic signed [C:0]       bay_out,
    output logic signed [2*C+2:0]   n1_out,
    output logic signed [2*C+2:0]   den_out,
    output logic signed [2*C+2:0]   n3_out
);

    localparam int DW = C + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;

    logic                 v1_reg, v2_reg, v3_reg;
    logic signed [C-1:0]  ax1_reg, ay1_reg, ax2_reg, ay2_reg, ax3_reg, ay3_reg;
    logic signed [DW-1:0] bax1_reg, bay1_reg, dcx1_reg, dcy1_reg, acx1_reg, acy1_reg;
    logic signed [DW-1:0] bax2_reg, bay2_reg, bax3_reg, bay3_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [XW-1:0] n1_reg, den_reg, n3_reg;

    function automatic logic signed [DW-1:0] sub_c(input logic signed [C-1:0] a,
                                                  input logic signed [C-1:0] b);
        return $signed({a[C-1], a}) - $signed({b[C-1], b});
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // Edge vectors.
        ax1_reg  <= ax;
        ay1_reg  <= ay;
        bax1_reg <= sub_c(bx, ax);
        bay1_reg <= sub_c(by, ay);
        dcx1_reg <= sub_c(dx, cx);
        dcy1_reg <= sub_c(dy, cy);
        acx1_reg <= sub_c(ax, cx);
        acy1_reg <= sub_c(ay, cy);
        // Six products.
        ax2_reg  <= ax1_reg;
        ay2_reg  <= ay1_reg;
        bax2_reg <= bax1_reg;
        bay2_reg <= bay1_reg;
        p0_reg   <= acy1_reg * dcx1_reg;
        p1_reg   <= acx1_reg * dcy1_reg;
        p2_reg   <= bax1_reg * dcy1_reg;
        p3_reg   <= bay1_reg * dcx1_reg;
        p4_reg   <= acy1_reg * bax1_reg;
        p5_reg   <= acx1_reg * bay1_reg;
        // Cross products.
        ax3_reg  <= ax2_reg;
        ay3_reg  <= ay2_reg;
        bax3_reg <= bax2_reg;
        bay3_reg <= bay2_reg;
        n1_reg   <= XW'(p0_reg) - XW'(p1_reg);
        den_reg  <= XW'(p2_reg) - XW'(p3_reg);
        n3_reg   <= XW'(p4_reg) - XW'(p5_reg);
    end

    assign out_valid = v3_reg;
    assign ax_out    = ax3_reg;
    assign ay_out    = ay3_reg;
    assign bax_out   = bax3_reg;
    assign bay_out   = bay3_reg;
    assign n1_out    = n1_reg;
    assign den_out   = den_reg;
    assign n3_out    = n3_reg;

endmodule

[hw/rtl/segment_intersection.sv]
// Channel   Ports                                      Handshake
// request   start, seg1_*, seg2_* (signed Q11.4)       taken when start is high and busy low
// result    done, status, cross_x, cross_y,            done high for one cycle per request
//           one_minus_r, one_minus_s
//
// A request is taken in any cycle; busy never rises, so one request per clock is sustained.
// QB, the number of quotient bits, one per divider pipeline stage, sets the latency.
// rst_n clears only the valid bits of the pipeline; data registers are not reset.
// The receiver cannot stall, so the pipeline never holds and nothing is dropped or repeated.
module segment_intersection #(
    parameter int COORD_BITS      = seg_pkg::COORD_BITS,
    parameter int PARAM_FRAC_BITS = seg_pkg::PARAM_FRAC_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [COORD_BITS-1:0]          seg1_start_x,
    input  logic signed [COORD_BITS-1:0]          seg1_start_y,
    input  logic signed [COORD_BITS-1:0]          seg1_end_x,
    input  logic signed [COORD_BITS-1:0]          seg1_end_y,
    input  logic signed [COORD_BITS-1:0]          seg2_start_x,
    input  logic signed [COORD_BITS-1:0]          seg2_start_y,
    input  logic signed [COORD_BITS-1:0]          seg2_end_x,
    input  logic signed [COORD_BITS-1:0]          seg2_end_y,
    output logic                                  done,
    output logic [1:0]                            status,
    output logic signed [COORD_BITS-1:0]          cross_x,
    output logic signed [COORD_BITS-1:0]          cross_y,
    output logic signed [seg_pkg::PARAM_BITS-1:0] one_minus_r,
    output logic signed [seg_pkg::PARAM_BITS-1:0] one_minus_s
);

    localparam int C   = COORD_BITS;
    localparam int PB  = seg_pkg::PARAM_BITS;
    localparam int DW  = C + 1;            // edge vector width
    localparam int XW  = 2 * DW + 1;       // cross product width
    localparam int NW  = XW + 1;           // numerator of 1-r and 1-s
    localparam int MW  = DW + XW;          // numerator of the point offsets
    // Quotient bits: enough for both the parameter and the offset results.
    localparam int QB  = (PB + 1 > C + 2) ? PB + 1 : C + 2;
    localparam int DL  = QB + 3;           // divider latency
    localparam int SBW = 2 + 2 * C;        // status and start point riding beside the dividers
    localparam int LAT = DL + 5;           // request to result

    // Front end: edge vectors, products and the three cross products.
    logic                 v3;
    logic signed [C-1:0]  ax3, ay3;
    logic signed [DW-1:0] bax3, bay3;
    logic signed [XW-1:0] n1_3, den3, n3_3;

    seg_cross #(
        .C (C)
    ) u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .ax        (seg1_start_x),
        .ay        (seg1_start_y),
        .bx        (seg1_end_x),
        .by        (seg1_end_y),
        .cx        (seg2_start_x),
        .cy        (seg2_start_y),
        .dx        (seg2_end_x),
        .dy        (seg2_end_y),
        .out_valid (v3),
        .ax_out    (ax3),
        .ay_out    (ay3),
        .bax_out   (bax3),
        .bay_out   (bay3),
        .n1_out    (n1_3),
        .den_out   (den3),
        .n3_out    (n3_3)
    );

    // Classification stage. The hit test compares the raw cross products with the
    // denominator, mirrored when the denominator is negative, so no rounding enters it.
    logic                 v4_reg;
    logic signed [C-1:0]  ax4_reg, ay4_reg;
    logic signed [XW-1:0] den4_reg;
    logic signed [NW-1:0] omr_num_reg, oms_num_reg;
    logic signed [MW-1:0] ox_num_reg, oy_num_reg;
    seg_pkg::status_t     stat4_reg;
    seg_pkg::status_t     stat_next;
    logic                 hit;

    always_comb
    begin
        if (den3 > 0)
        begin
            hit = (n1_3 >= 0) && (n1_3 <= den3) && (n3_3 >= 0) && (n3_3 <= den3);
        end
        else
        begin
            hit = (n1_3 <= 0) && (n1_3 >= den3) && (n3_3 <= 0) && (n3_3 >= den3);
        end

        if (den3 == 0)
        begin
            stat_next = (n1_3 == 0) ? seg_pkg::STAT_COLLINEAR : seg_pkg::STAT_PARALLEL;
        end
        else if (hit)
        begin
            stat_next = seg_pkg::STAT_HIT;
        end
        else
        begin
            stat_next = seg_pkg::STAT_OUTSIDE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3;
        end
    end

    always_ff @(posedge clk)
    begin
        ax4_reg     <= ax3;
        ay4_reg     <= ay3;
        den4_reg    <= den3;
        stat4_reg   <= stat_next;
        omr_num_reg <= NW'(den3) - NW'(n1_3);
        oms_num_reg <= NW'(den3) - NW'(n3_3);
        ox_num_reg  <= bax3 * n1_3;
        oy_num_reg  <= bay3 * n1_3;
    end

    // Four divider pipelines of equal latency.
    logic signed [PB-1:0] omr_q, oms_q;
    logic signed [C:0]    ox_q, oy_q;

    seg_div #(
        .NUM_W (NW), .DEN_W (XW), .SHIFT (PARAM_FRAC_BITS + 1), .QB (QB), .OUT_W (PB)
    ) u_div_r (
        .clk (clk), .num (omr_num_reg), .den (den4_reg), .quo (omr_q)
    );

    seg_div #(
        .NUM_W (NW), .DEN_W (XW), .SHIFT (PARAM_FRAC_BITS + 1), .QB (QB), .OUT_W (PB)
    ) u_div_s (
        .clk (clk), .num (oms_num_reg), .den (den4_reg), .quo (oms_q)
    );

    seg_div #(
        .NUM_W (MW), .DEN_W (XW), .SHIFT (1), .QB (QB), .OUT_W (C + 1)
    ) u_div_x (
        .clk (clk), .num (ox_num_reg), .den (den4_reg), .quo (ox_q)
    );

    seg_div #(
        .NUM_W (MW), .DEN_W (XW), .SHIFT (1), .QB (QB), .OUT_W (C + 1)
    ) u_div_y (
        .clk (clk), .num (oy_num_reg), .den (den4_reg), .quo (oy_q)
    );

    // Status and start point follow the dividers with the valid bit.
    logic           vd;
    logic [SBW-1:0] sbd;

    seg_dly #(
        .WIDTH (SBW),
        .DEPTH (DL)
    ) u_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_data   ({stat4_reg, ax4_reg, ay4_reg}),
        .out_valid (vd),
        .out_data  (sbd)
    );

    // Result register. Fields that do not apply to the case are forced to zero.
    logic [1:0]      stat_d;
    logic [C-1:0]    axd, ayd;
    logic            done_reg;
    logic [1:0]      status_reg;
    logic [C-1:0]    cross_x_reg, cross_y_reg;
    logic [PB-1:0]   omr_reg, oms_reg;

    assign stat_d = sbd[SBW-1 -: 2];
    assign axd    = sbd[2*C-1 -: C];
    assign ayd    = sbd[C-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vd;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= stat_d;
        if (stat_d == seg_pkg::STAT_HIT)
        begin
            cross_x_reg <= axd + ox_q[C-1:0];
            cross_y_reg <= ayd + oy_q[C-1:0];
        end
        else
        begin
            cross_x_reg <= '0;
            cross_y_reg <= '0;
        end
        if (stat_d == seg_pkg::STAT_COLLINEAR || stat_d == seg_pkg::STAT_PARALLEL)
        begin
            omr_reg <= '0;
            oms_reg <= '0;
        end
        else
        begin
            omr_reg <= omr_q;
            oms_reg <= oms_q;
        end
    end

    assign busy        = 1'b0;
    assign done        = done_reg;
    assign status      = status_reg;
    assign cross_x     = $signed(cross_x_reg);
    assign cross_y     = $signed(cross_y_reg);
    assign one_minus_r = $signed(omr_reg);
    assign one_minus_s = $signed(oms_reg);

    // Every result traces back to an earlier request.
    a_done_latency : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without matching request");

    // The point is only reported on a hit.
    a_point_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != seg_pkg::STAT_HIT) |-> (cross_x == 0 && cross_y == 0))
        else $error("point given without a hit");

    // Parallel and collinear cases carry no line parameters.
    a_param_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == seg_pkg::STAT_COLLINEAR || status == seg_pkg::STAT_PARALLEL))
        |-> (one_minus_r == 0 && one_minus_s == 0))
        else $error("parameters given for parallel lines");

endmodule

[bench/segment_checker.sv]
`timescale 1ns / 1ps

module segment_checker
    import seg_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic signed [COORD_BITS-1:0] seg1_start_x,
    input  logic signed [COORD_BITS-1:0] seg1_start_y,
    input  logic signed [COORD_BITS-1:0] seg1_end_x,
    input  logic signed [COORD_BITS-1:0] seg1_end_y,
    input  logic signed [COORD_BITS-1:0] seg2_start_x,
    input  logic signed [COORD_BITS-1:0] seg2_start_y,
    input  logic signed [COORD_BITS-1:0] seg2_end_x,
    input  logic signed [COORD_BITS-1:0] seg2_end_y,
    input  logic                         done,
    input  logic [1:0]                   status,
    input  logic signed [COORD_BITS-1:0] cross_x,
    input  logic signed [COORD_BITS-1:0] cross_y,
    input  logic signed [PARAM_BITS-1:0] one_minus_r,
    input  logic signed [PARAM_BITS-1:0] one_minus_s,
    output int                           errors,
    output int                           pending
);

    typedef struct packed {
        status_t                      stat;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [PARAM_BITS-1:0] omr;
        logic signed [PARAM_BITS-1:0] oms;
    } crossing_t;

    crossing_t crossings_due[$];

    // Rounded quotient num/den scaled by 2^frac, ties away from zero, saturated to width bits.
    function automatic longint round_div(longint num, longint den, int frac, int width);
        logic signed [127:0] n;
        logic signed [127:0] d;
        logic signed [127:0] q;
        logic signed [127:0] lim;
        n = 128'(num) <<< frac;
        d = 128'(den);
        if (n < 0) n = -n;
        if (d < 0) d = -d;
        q = (2 * n + d) / (2 * d);
        if ((num < 0) != (den < 0)) q = -q;
        lim = 128'sd1 <<< (width - 1);
        if (q > lim - 1) q = lim - 1;
        if (q < -lim) q = -lim;
        return longint'(q);
    endfunction

    function automatic crossing_t predict_crossing(longint ax, longint ay, longint bx, longint by,
                                                   longint cx, longint cy, longint dx,
                                                   longint dy);
        crossing_t res;
        longint n1, den, n3, p1, p2, p3, ox, oy;
        res = '0;
        n1 = (ay - cy) * (dx - cx) - (ax - cx) * (dy - cy);
        den = (bx - ax) * (dy - cy) - (by - ay) * (dx - cx);
        n3 = (ay - cy) * (bx - ax) - (ax - cx) * (by - ay);
        if (den == 0)
        begin
            res.stat = (n1 == 0) ? STAT_COLLINEAR : STAT_PARALLEL;
            return res;
        end
        res.omr = PARAM_BITS'(round_div(den - n1, den, PARAM_FRAC_BITS, PARAM_BITS));
        res.oms = PARAM_BITS'(round_div(den - n3, den, PARAM_FRAC_BITS, PARAM_BITS));
        p1 = (den < 0) ? -n1 : n1;
        p2 = (den < 0) ? -den : den;
        p3 = (den < 0) ? -n3 : n3;
        if (p1 >= 0 && p1 <= p2 && p3 >= 0 && p3 <= p2)
        begin
            ox = round_div((bx - ax) * n1, den, 0, COORD_BITS + 1);
            oy = round_div((by - ay) * n1, den, 0, COORD_BITS + 1);
            res.stat = STAT_HIT;
            res.px = COORD_BITS'(ax + ox);
            res.py = COORD_BITS'(ay + oy);
        end
        else
            res.stat = STAT_OUTSIDE;
        return res;
    endfunction

    assign pending = crossings_due.size();

    initial errors = 0;

    always @(posedge clk)
    begin
        crossing_t want;
        if (rst_n && done)
        begin
            if (crossings_due.size() == 0)
            begin
                $display("%0t: result with no request waiting, status %0d", $time, status);
                errors <= errors + 1;
            end
            else
            begin
                want = crossings_due.pop_front();
                if (status !== want.stat || cross_x !== want.px || cross_y !== want.py ||
                    one_minus_r !== want.omr || one_minus_s !== want.oms)
                begin
                    $display("%0t: expected st=%0d x=%0d y=%0d 1-r=%0d 1-s=%0d", $time,
                             want.stat, want.px, want.py, want.omr, want.oms);
                    $display("%0t: actual   st=%0d x=%0d y=%0d 1-r=%0d 1-s=%0d", $time,
                             status, cross_x, cross_y, one_minus_r, one_minus_s);
                    errors <= errors + 1;
                end
            end
        end
        // A request enters the queue after any result of this edge has been popped.
        if (rst_n && start && !busy)
            crossings_due.push_back(predict_crossing(seg1_start_x, seg1_start_y, seg1_end_x,
                                                     seg1_end_y, seg2_start_x, seg2_start_y,
                                                     seg2_end_x, seg2_end_y));
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import seg_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    logic done;
    logic [1:0] status;
    logic signed [COORD_BITS-1:0] cross_x, cross_y;
    logic signed [PARAM_BITS-1:0] one_minus_r, one_minus_s;
    int errors;
    int pending;

    // Free-running 100 MHz clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    segment_intersection u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .seg1_start_x(ax), .seg1_start_y(ay), .seg1_end_x(bx), .seg1_end_y(by),
        .seg2_start_x(cx), .seg2_start_y(cy), .seg2_end_x(dx), .seg2_end_y(dy),
        .done(done), .status(status), .cross_x(cross_x), .cross_y(cross_y),
        .one_minus_r(one_minus_r), .one_minus_s(one_minus_s)
    );

    segment_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .seg1_start_x(ax), .seg1_start_y(ay), .seg1_end_x(bx), .seg1_end_y(by),
        .seg2_start_x(cx), .seg2_start_y(cy), .seg2_end_x(dx), .seg2_end_y(dy),
        .done(done), .status(status), .cross_x(cross_x), .cross_y(cross_y),
        .one_minus_r(one_minus_r), .one_minus_s(one_minus_s),
        .errors(errors), .pending(pending)
    );

    // Random gaps are switched off for one long stretch in the middle of the run.
    bit gaps_on = 1'b1;

    // Drives one request and holds it until accepted. Start stays high between
    // back-to-back requests, since it is only lowered when a gap is taken.
    task automatic send_request(input logic [15:0] v0, v1, v2, v3, v4, v5, v6, v7);
        while (gaps_on && $urandom_range(99) < 27)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        ax <= v0; ay <= v1; bx <= v2; by <= v3;
        cx <= v4; cy <= v5; dx <= v6; dy <= v7;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(64)) - 32);
            2: return ($urandom_range(1)) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(2000)) - 1000);
        endcase
    endfunction

    // Builds segment pairs of several shapes: free, degenerate, parallel, collinear
    // and ones that share an endpoint.
    task automatic send_random_pair();
        logic [15:0] v[8];
        int mode;
        int shape;
        logic [15:0] ox, oy;
        mode = $urandom_range(3);
        for (int i = 0; i < 8; i++)
            v[i] = rand_coord(mode);
        shape = $urandom_range(9);
        ox = 16'($signed($urandom_range(40)) - 20);
        oy = 16'($signed($urandom_range(40)) - 20);
        if (shape == 0)
        begin
            // Parallel: CD is AB shifted.
            v[4] = v[0] + ox; v[5] = v[1] + oy; v[6] = v[2] + ox; v[7] = v[3] + oy;
        end
        else if (shape == 1)
        begin
            // Collinear: C and D lie on the line through A and B.
            v[4] = 16'(v[0] + 2 * (v[2] - v[0])); v[5] = 16'(v[1] + 2 * (v[3] - v[1]));
            v[6] = v[0] - (v[2] - v[0]); v[7] = v[1] - (v[3] - v[1]);
        end
        else if (shape == 2)
        begin
            // Shared endpoint.
            v[4] = v[2]; v[5] = v[3];
        end
        else if (shape == 3)
        begin
            // A degenerate first segment.
            v[2] = v[0]; v[3] = v[1];
        end
        send_request(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        {ax, ay, bx, by, cx, cy, dx, dy} = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests: crossing, outside, parallel, collinear, extremes.
        send_request(0, 0, 160, 160, 0, 160, 160, 0);
        send_request(0, 0, 16, 16, 0, 160, 160, 0);
        send_request(0, 0, 160, 0, 0, 16, 160, 16);
        send_request(0, 0, 16, 0, 32, 0, 64, 0);
        send_request(0, 0, 0, 0, 0, 0, 0, 0);
        send_request(16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                     16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_request(16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                     16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
        send_request(16'hffff, 16'hffff, 16'h8000, 16'h8000, 0, 0, 16'h7fff, 1);
        send_request(0, 0, 1, 0, 0, 16'h8000, 1, 16'h7fff);
        send_request(0, 0, 160, 0, 160, 0, 160, 160);
        send_request(0, 0, 1, 1, 16'h7fff, 0, 16'h7ffe, 1);
        send_request(16'h5555, 16'haaaa, 16'haaaa, 16'h5555,
                     16'h5555, 16'h5555, 16'haaaa, 16'haaaa);

        // Hold the sender off until the pipeline has drained completely.
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        for (int n = 0; n < 1000; n++)
        begin
            gaps_on = !(n >= 400 && n < 550);
            send_random_pair();
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
